// ===== sv/lsm_pkg.sv =====
package lsm_pkg;

    // block sizing
    localparam int NUM_OPS   = 3;
    localparam int COUNT_W   = 32;
    localparam int LAT_W     = 32;
    localparam int SUM_W     = 48;
    localparam int OP_IDX_W  = (NUM_OPS > 1) ? $clog2(NUM_OPS) : 1;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    // fixed field widths
    localparam int ACT_W     = 2;
    localparam int CODE_W    = 16;
    localparam int DUR_W     = 32;
    localparam int OUT_W     = 32;
    localparam int GEN_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // saturation limits in a common 64-bit form
    localparam logic [63:0] LAT_MAX64 = (64'd1 << LAT_W) - 64'd1;
    localparam logic [63:0] SUM_MAX64 = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] OUT_MAX64 = (64'd1 << OUT_W) - 64'd1;

    typedef logic [COUNT_W-1:0]  t_cnt;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [LAT_W-1:0]    t_lat;
    typedef logic [CODE_W-1:0]   t_code;
    typedef logic [DUR_W-1:0]    t_dur;
    typedef logic [OUT_W-1:0]    t_out;
    typedef logic [GEN_W-1:0]    t_gen;
    typedef logic [OP_IDX_W-1:0] t_idx;

    // action codes of an input item
    typedef enum logic [ACT_W-1:0] {
        ACT_OBSERVE = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_CLEAR   = 2'd2
    } t_action;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXP_VERSION  = 3'd0,
        CFG_FIRST_OP     = 3'd1,
        CFG_SUCCESS      = 3'd2,
        CFG_TIMEOUT      = 3'd3,
        CFG_LAST_OUTCOME = 3'd4
    } t_cfg_idx;

    localparam t_code RST_EXP_VERSION  = 16'd1;
    localparam t_code RST_FIRST_OP     = 16'd1;
    localparam t_code RST_SUCCESS      = 16'd0;
    localparam t_code RST_TIMEOUT      = 16'd1;
    localparam t_code RST_LAST_OUTCOME = 16'd2;
    localparam t_gen  RST_GENERATION   = 32'd1;

    // outcome class of an accepted observation
    typedef enum logic [1:0] {
        CLS_SUCCESS,
        CLS_TIMEOUT,
        CLS_ERROR
    } t_cls;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_OBS,
        S_ACC,
        S_DSTART,
        S_DIV,
        S_CLR,
        S_OUT
    } t_state;

    // update command toward the per-operation store
    typedef struct packed {
        logic upd;
        logic clr;
        t_lat lat;
        t_cls cls;
    } t_store_cmd;

    // statistics of one operation
    typedef struct packed {
        t_cnt req;
        t_cnt suc;
        t_cnt err;
        t_cnt tmo;
        t_sum sum;
        t_lat mn;
        t_lat mx;
    } t_op_stats;

    // one snapshot result
    typedef struct packed {
        t_out generation;
        t_out request_count;
        t_out success_count;
        t_out error_count;
        t_out timeout_count;
        t_out min_latency;
        t_out max_latency;
        t_out avg_latency;
        t_out observations_received;
        t_out malformed_rejected;
    } t_result;

    function automatic t_cnt cnt_add(t_cnt a, t_cnt b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
    endfunction

    function automatic t_cnt cnt_inc(t_cnt a);
        return cnt_add(a, t_cnt'(1));
    endfunction

    function automatic t_sum sum_add(t_sum a, t_sum b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic t_sum sum_add_lat(t_sum a, t_lat l);
        logic [64:0] s;
        s = 65'(a) + 65'(l);
        return (s > 65'(SUM_MAX64)) ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic t_gen gen_inc(t_gen a);
        logic [GEN_W:0] s;
        s = {1'b0, a} + (GEN_W + 1)'(1);
        return s[GEN_W] ? '1 : s[GEN_W-1:0];
    endfunction

    function automatic t_lat lat_clip(t_dur d);
        logic [63:0] d64;
        d64 = 64'(d);
        return (d64 > LAT_MAX64) ? '1 : d64[LAT_W-1:0];
    endfunction

    function automatic t_out clip_out(logic [63:0] v);
        return (v > OUT_MAX64) ? '1 : v[OUT_W-1:0];
    endfunction

endpackage

// ===== sv/lsm_in_if.sv =====
interface lsm_in_if;
    import lsm_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic                length_ok;
    logic [CODE_W-1:0]   version;
    logic [CODE_W-1:0]   operation;
    logic [CODE_W-1:0]   outcome;
    logic [DUR_W-1:0]    duration;

    modport source (
        output valid, action, length_ok, version, operation, outcome, duration,
        input  ready
    );

    modport sink (
        input  valid, action, length_ok, version, operation, outcome, duration,
        output ready
    );

endinterface

// ===== sv/lsm_out_if.sv =====
interface lsm_out_if;
    import lsm_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] generation;
    logic [OUT_W-1:0] request_count;
    logic [OUT_W-1:0] success_count;
    logic [OUT_W-1:0] error_count;
    logic [OUT_W-1:0] timeout_count;
    logic [OUT_W-1:0] min_latency;
    logic [OUT_W-1:0] max_latency;
    logic [OUT_W-1:0] avg_latency;
    logic [OUT_W-1:0] observations_received;
    logic [OUT_W-1:0] malformed_rejected;

    modport source (
        output valid, generation, request_count, success_count, error_count,
               timeout_count, min_latency, max_latency, avg_latency,
               observations_received, malformed_rejected,
        input  ready
    );

    modport sink (
        input  valid, generation, request_count, success_count, error_count,
               timeout_count, min_latency, max_latency, avg_latency,
               observations_received, malformed_rejected,
        output ready
    );

endinterface

// ===== sv/latency_stats_monitor.sv =====
// Request latency statistics counter. Each input transfer carries one action:
// an observation (version, operation, outcome, latency) that updates the
// counters of one of NUM_OPS operations or bumps the reject count, a query that
// returns one snapshot of totals, min, max and average latency, or a clear that
// zeroes the statistics, advances the generation and returns it. Counters
// saturate. The block takes one item at a time. A query runs a sweep over the
// operation store with one accumulate per cycle, then a restoring divider that
// yields one quotient bit per cycle for the average. A finished result sits in
// an output register, so the next item can be taken while it waits.
// Configuration writes are expected only while the block idles.
module latency_stats_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lsm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lsm_pkg::CFG_W-1:0]       i_cfg_data,
    lsm_in_if.sink                          i_item,
    lsm_out_if.source                       o_result
);
    import lsm_pkg::*;

    // configuration
    t_code r_exp_ver;
    t_code r_first_op;
    t_code r_success;
    t_code r_timeout;
    t_code r_last_oc;

    // sequencer
    t_state r_state;
    t_state n_state;

    // captured item
    logic  r_obs_ok;
    t_idx  r_idx;
    t_lat  r_lat;
    t_cls  r_cls;
    logic  r_is_clear;

    // totals and accumulators
    t_gen  r_gen;
    t_cnt  r_acc_total;
    t_cnt  r_rej_total;
    t_idx  r_cnt;
    t_cnt  r_acc_req;
    t_cnt  r_acc_suc;
    t_cnt  r_acc_err;
    t_cnt  r_acc_tmo;
    t_sum  r_acc_sum;
    t_lat  r_acc_mn;
    t_lat  r_acc_mx;

    // output register
    t_result r_res;
    t_result n_res;
    logic    r_out_valid;

    // decode and control
    logic [CODE_W:0] op_diff;
    logic            op_in_range;
    logic            obs_ok;
    t_cls            obs_cls;
    logic            in_xfer;
    logic            out_xfer;
    logic            out_free;
    logic            in_ready;
    logic            acc_en;
    logic            div_start;
    logic            out_load;
    logic            rej_inc;
    logic            obs_inc;
    t_store_cmd      store_cmd;
    t_idx            store_idx;
    t_op_stats       rd;
    logic            div_done;
    t_sum            div_quo;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver  <= RST_EXP_VERSION;
            r_first_op <= RST_FIRST_OP;
            r_success  <= RST_SUCCESS;
            r_timeout  <= RST_TIMEOUT;
            r_last_oc  <= RST_LAST_OUTCOME;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_EXP_VERSION:  r_exp_ver  <= i_cfg_data;
                CFG_FIRST_OP:     r_first_op <= i_cfg_data;
                CFG_SUCCESS:      r_success  <= i_cfg_data;
                CFG_TIMEOUT:      r_timeout  <= i_cfg_data;
                CFG_LAST_OUTCOME: r_last_oc  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // observation check at the input transfer
    assign op_diff     = {1'b0, i_item.operation} - {1'b0, r_first_op};
    assign op_in_range = !op_diff[CODE_W] && (op_diff[CODE_W-1:0] < CODE_W'(NUM_OPS));
    assign obs_ok      = i_item.length_ok && (i_item.version == r_exp_ver) &&
                         op_in_range && (i_item.outcome <= r_last_oc);

    always_comb begin
        if (i_item.outcome == r_success) begin
            obs_cls = CLS_SUCCESS;
        end else if (i_item.outcome == r_timeout) begin
            obs_cls = CLS_TIMEOUT;
        end else begin
            obs_cls = CLS_ERROR;
        end
    end

    assign in_xfer  = i_item.valid && in_ready;
    assign out_xfer = r_out_valid && o_result.ready;
    assign out_free = !r_out_valid || o_result.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_item.action)
                        ACT_OBSERVE: n_state = S_OBS;
                        ACT_QUERY:   n_state = S_ACC;
                        ACT_CLEAR:   n_state = S_CLR;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_OBS: n_state = S_IDLE;
            S_ACC: begin
                if (r_cnt == OP_IDX_W'(NUM_OPS - 1)) begin
                    n_state = S_DSTART;
                end
            end
            S_DSTART: n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_CLR: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready  = 1'b0;
        acc_en    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        rej_inc   = 1'b0;
        obs_inc   = 1'b0;
        store_cmd = '{upd: 1'b0, clr: 1'b0, lat: r_lat, cls: r_cls};
        store_idx = r_idx;
        case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_OBS: begin
                store_cmd.upd = r_obs_ok;
                obs_inc       = r_obs_ok;
                rej_inc       = !r_obs_ok;
            end
            S_ACC: begin
                acc_en    = 1'b1;
                store_idx = r_cnt;
            end
            S_DSTART: div_start = 1'b1;
            S_CLR:    store_cmd.clr = 1'b1;
            S_OUT:    out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture of the accepted item
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_obs_ok   <= obs_ok;
            r_idx      <= op_diff[OP_IDX_W-1:0];
            r_lat      <= lat_clip(i_item.duration);
            r_cls      <= obs_cls;
            r_is_clear <= (i_item.action == ACT_CLEAR);
        end
    end

    // accept, reject and generation counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen       <= RST_GENERATION;
            r_acc_total <= '0;
            r_rej_total <= '0;
        end else if (store_cmd.clr) begin
            r_gen       <= gen_inc(r_gen);
            r_acc_total <= '0;
            r_rej_total <= '0;
        end else begin
            if (obs_inc) begin
                r_acc_total <= cnt_inc(r_acc_total);
            end
            if (rej_inc) begin
                r_rej_total <= cnt_inc(r_rej_total);
            end
        end
    end

    // snapshot sweep, one operation per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_xfer) begin
            r_cnt <= '0;
        end else if (acc_en) begin
            r_cnt <= r_cnt + OP_IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_acc_req <= '0;
            r_acc_suc <= '0;
            r_acc_err <= '0;
            r_acc_tmo <= '0;
            r_acc_sum <= '0;
            r_acc_mn  <= '0;
            r_acc_mx  <= '0;
        end else if (acc_en) begin
            r_acc_req <= cnt_add(r_acc_req, rd.req);
            r_acc_suc <= cnt_add(r_acc_suc, rd.suc);
            r_acc_err <= cnt_add(r_acc_err, rd.err);
            r_acc_tmo <= cnt_add(r_acc_tmo, rd.tmo);
            r_acc_sum <= sum_add(r_acc_sum, rd.sum);
            // a zero running minimum counts as unset
            if (rd.req != '0) begin
                if (r_acc_mn == '0 || rd.mn < r_acc_mn) begin
                    r_acc_mn <= rd.mn;
                end
                if (rd.mx > r_acc_mx) begin
                    r_acc_mx <= rd.mx;
                end
            end
        end
    end

    lsm_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (store_cmd),
        .i_idx   (store_idx),
        .o_rd    (rd)
    );

    lsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_acc_sum),
        .i_divisor  (r_acc_req),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // result assembly; a clear returns only the new generation
    always_comb begin
        n_res            = '0;
        n_res.generation = clip_out(64'(r_gen));
        if (!r_is_clear) begin
            n_res.request_count         = clip_out(64'(r_acc_req));
            n_res.success_count         = clip_out(64'(r_acc_suc));
            n_res.error_count           = clip_out(64'(r_acc_err));
            n_res.timeout_count         = clip_out(64'(r_acc_tmo));
            n_res.min_latency           = clip_out(64'(r_acc_mn));
            n_res.max_latency           = clip_out(64'(r_acc_mx));
            n_res.avg_latency           = (r_acc_req == '0) ? '0 : clip_out(64'(div_quo));
            n_res.observations_received = clip_out(64'(r_acc_total));
            n_res.malformed_rejected    = clip_out(64'(r_rej_total));
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_res <= n_res;
        end
    end

    assign i_item.ready                   = in_ready;
    assign o_result.valid                 = r_out_valid;
    assign o_result.generation            = r_res.generation;
    assign o_result.request_count         = r_res.request_count;
    assign o_result.success_count         = r_res.success_count;
    assign o_result.error_count           = r_res.error_count;
    assign o_result.timeout_count         = r_res.timeout_count;
    assign o_result.min_latency           = r_res.min_latency;
    assign o_result.max_latency           = r_res.max_latency;
    assign o_result.avg_latency           = r_res.avg_latency;
    assign o_result.observations_received = r_res.observations_received;
    assign o_result.malformed_rejected    = r_res.malformed_rejected;

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside of divide state");

    // sweep index stays within the operation store
    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_cnt <= OP_IDX_W'(NUM_OPS - 1)))
        else $error("snapshot sweep index out of range");

    // a clear zeroes the totals and goes on to deliver its result
    a_clear_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |=>
            (r_acc_total == '0 && r_rej_total == '0 && r_state == S_OUT))
        else $error("clear did not zero totals");

    // a loaded result is presented in the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

// ===== sv/lsm_store.sv =====
module lsm_store (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lsm_pkg::t_store_cmd    i_cmd,
    input  lsm_pkg::t_idx          i_idx,
    output lsm_pkg::t_op_stats     o_rd
);
    import lsm_pkg::*;

    t_op_stats r_ops [NUM_OPS];
    t_op_stats cur;
    t_op_stats n_entry;
    t_cnt      req_new;

    // single read port, shared by update and snapshot sweep
    assign cur  = r_ops[i_idx];
    assign o_rd = cur;

    // saturating update of one operation
    always_comb begin
        n_entry = cur;
        req_new = cnt_inc(cur.req);
        n_entry.req = req_new;
        n_entry.sum = sum_add_lat(cur.sum, i_cmd.lat);
        if (req_new == t_cnt'(1) || i_cmd.lat < cur.mn) begin
            n_entry.mn = i_cmd.lat;
        end
        if (i_cmd.lat > cur.mx) begin
            n_entry.mx = i_cmd.lat;
        end
        case (i_cmd.cls)
            CLS_SUCCESS: n_entry.suc = cnt_inc(cur.suc);
            CLS_TIMEOUT: n_entry.tmo = cnt_inc(cur.tmo);
            default:     n_entry.err = cnt_inc(cur.err);
        endcase
    end

    // store registers, cleared together by reset or a clear action
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            for (int k = 0; k < NUM_OPS; k++) begin
                r_ops[k] <= '0;
            end
        end else if (i_cmd.upd) begin
            r_ops[i_idx] <= n_entry;
        end
    end

endmodule

// ===== sv/lsm_div.sv =====
module lsm_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  lsm_pkg::t_sum  i_dividend,
    input  lsm_pkg::t_cnt  i_divisor,
    output logic           o_done,
    output lsm_pkg::t_sum  o_quotient
);
    import lsm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    t_cnt                 r_rem;
    t_sum                 r_quo;
    t_cnt                 r_dvs;
    logic [COUNT_W:0]     shift_val;
    logic [COUNT_W:0]     diff_val;
    logic                 fits;

    // one restoring step per cycle
    assign shift_val = {r_rem, r_quo[SUM_W-1]};
    assign diff_val  = shift_val - {1'b0, r_dvs};
    assign fits      = (shift_val >= {1'b0, r_dvs});

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff_val[COUNT_W-1:0] : shift_val[COUNT_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import lsm_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int RESULT_FIELDS = 10;
    localparam int REPORT_LIMIT  = 10;

    // action code the block ignores
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [ACT_W-1:0] act;
        logic             len_ok;
        t_code            ver;
        t_code            op;
        t_code            oc;
        t_dur             dur;
    } t_stat_item;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    lsm_in_if  item_if ();
    lsm_out_if res_if ();

    latency_stats_monitor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (res_if)
    );

    // predicted configuration and statistics
    t_code want_version;
    t_code op_base;
    t_code ok_code;
    t_code tmo_code;
    t_code outcome_limit;

    t_cnt  tally_req [NUM_OPS];
    t_cnt  tally_ok  [NUM_OPS];
    t_cnt  tally_err [NUM_OPS];
    t_cnt  tally_tmo [NUM_OPS];
    t_sum  tally_sum [NUM_OPS];
    t_lat  tally_min [NUM_OPS];
    t_lat  tally_max [NUM_OPS];
    t_gen  gen_now;
    t_cnt  seen_ok;
    t_cnt  seen_bad;

    t_result    snapshot_q [$];
    t_stat_item pending_items [$];
    t_stat_item next_item;
    t_stat_item taken_item;

    bit in_xfer;
    bit out_xfer;
    bit drv_holding;
    bit quiet_mode;
    bit long_hold_req;
    int send_gap;
    int recv_gap;
    int hold_left;
    int idle_cycles;
    int mismatch_count;

    string field_name [RESULT_FIELDS] = '{
        "generation", "request_count", "success_count", "error_count",
        "timeout_count", "min_latency", "max_latency", "avg_latency",
        "observations_received", "malformed_rejected"
    };

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] ceiling_at(logic [63:0] v, int w);
        logic [63:0] top;
        top = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        return (v > top) ? top : v;
    endfunction

    function automatic t_cnt bump(t_cnt v);
        return (&v) ? v : v + t_cnt'(1);
    endfunction

    function automatic void clear_tallies();
        for (int i = 0; i < NUM_OPS; i++) begin
            tally_req[i] = '0;
            tally_ok[i]  = '0;
            tally_err[i] = '0;
            tally_tmo[i] = '0;
            tally_sum[i] = '0;
            tally_min[i] = '0;
            tally_max[i] = '0;
        end
        seen_ok  = '0;
        seen_bad = '0;
    endfunction

    // update one operation's statistics or count a reject
    function automatic void record_observation(t_stat_item itm);
        int unsigned op32;
        int unsigned base32;
        int unsigned slot;
        t_lat        lat;
        op32   = 32'(itm.op);
        base32 = 32'(op_base);
        if (!itm.len_ok || itm.ver != want_version || op32 < base32
                || op32 - base32 >= NUM_OPS || itm.oc > outcome_limit) begin
            seen_bad = bump(seen_bad);
            return;
        end
        slot = op32 - base32;
        lat  = t_lat'(ceiling_at(64'(itm.dur), LAT_W));
        tally_req[slot] = bump(tally_req[slot]);
        tally_sum[slot] = t_sum'(ceiling_at(64'(tally_sum[slot]) + 64'(lat), SUM_W));
        if (tally_req[slot] == t_cnt'(1) || lat < tally_min[slot])
            tally_min[slot] = lat;
        if (lat > tally_max[slot])
            tally_max[slot] = lat;
        // success wins when both codes match
        if (itm.oc == ok_code)
            tally_ok[slot] = bump(tally_ok[slot]);
        else if (itm.oc == tmo_code)
            tally_tmo[slot] = bump(tally_tmo[slot]);
        else
            tally_err[slot] = bump(tally_err[slot]);
        seen_ok = bump(seen_ok);
    endfunction

    // totals over all operations
    function automatic t_result take_snapshot();
        logic [63:0] req;
        logic [63:0] suc;
        logic [63:0] err;
        logic [63:0] tmo;
        logic [63:0] sum;
        logic [63:0] avg;
        t_lat        mn;
        t_lat        mx;
        t_result     r;
        req = '0;
        suc = '0;
        err = '0;
        tmo = '0;
        sum = '0;
        mn  = '0;
        mx  = '0;
        for (int i = 0; i < NUM_OPS; i++) begin
            req += 64'(tally_req[i]);
            suc += 64'(tally_ok[i]);
            err += 64'(tally_err[i]);
            tmo += 64'(tally_tmo[i]);
            sum += 64'(tally_sum[i]);
            // a zero running minimum counts as unset
            if (tally_req[i] != '0) begin
                if (mn == '0 || tally_min[i] < mn)
                    mn = tally_min[i];
                if (tally_max[i] > mx)
                    mx = tally_max[i];
            end
        end
        req = ceiling_at(req, COUNT_W);
        suc = ceiling_at(suc, COUNT_W);
        err = ceiling_at(err, COUNT_W);
        tmo = ceiling_at(tmo, COUNT_W);
        sum = ceiling_at(sum, SUM_W);
        avg = (req == '0) ? '0 : sum / req;
        r.generation            = t_out'(ceiling_at(64'(gen_now), OUT_W));
        r.request_count         = t_out'(ceiling_at(req, OUT_W));
        r.success_count         = t_out'(ceiling_at(suc, OUT_W));
        r.error_count           = t_out'(ceiling_at(err, OUT_W));
        r.timeout_count         = t_out'(ceiling_at(tmo, OUT_W));
        r.min_latency           = t_out'(ceiling_at(64'(mn), OUT_W));
        r.max_latency           = t_out'(ceiling_at(64'(mx), OUT_W));
        r.avg_latency           = t_out'(ceiling_at(avg, OUT_W));
        r.observations_received = t_out'(ceiling_at(64'(seen_ok), OUT_W));
        r.malformed_rejected    = t_out'(ceiling_at(64'(seen_bad), OUT_W));
        return r;
    endfunction

    // apply one accepted item to the prediction
    function automatic void stats_step(t_stat_item itm);
        t_result r;
        case (itm.act)
            ACT_OBSERVE: record_observation(itm);
            ACT_QUERY: snapshot_q.push_back(take_snapshot());
            ACT_CLEAR: begin
                clear_tallies();
                gen_now = (&gen_now) ? gen_now : gen_now + t_gen'(1);
                r = '0;
                r.generation = gen_now;
                snapshot_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic void note_mismatch(string what, t_out want, t_out got);
        if (mismatch_count < REPORT_LIMIT)
            $display("%0t mismatch %s: expected %h, got %h", $time, what, want, got);
        mismatch_count++;
    endfunction

    function automatic void check_snapshot(t_result got);
        t_result want;
        if (snapshot_q.size() == 0) begin
            note_mismatch("result with nothing pending, generation", '0, got.generation);
            return;
        end
        want = snapshot_q.pop_front();
        for (int f = 0; f < RESULT_FIELDS; f++) begin
            if (want[(RESULT_FIELDS-1-f)*OUT_W +: OUT_W] !== got[(RESULT_FIELDS-1-f)*OUT_W +: OUT_W])
                note_mismatch(field_name[f], want[(RESULT_FIELDS-1-f)*OUT_W +: OUT_W],
                              got[(RESULT_FIELDS-1-f)*OUT_W +: OUT_W]);
        end
    endfunction

    function automatic t_stat_item make_item(logic [ACT_W-1:0] act, logic len_ok,
                                             t_code ver, t_code op, t_code oc, t_dur dur);
        t_stat_item itm;
        itm.act    = act;
        itm.len_ok = len_ok;
        itm.ver    = ver;
        itm.op     = op;
        itm.oc     = oc;
        itm.dur    = dur;
        return itm;
    endfunction

    // mostly well-formed observations under the current settings
    function automatic t_stat_item random_item();
        t_stat_item  itm;
        int unsigned pick;
        int unsigned op32;
        pick       = $urandom_range(0, 99);
        itm.act    = ACT_OBSERVE;
        itm.len_ok = 1'b1;
        itm.ver    = want_version;
        op32       = 32'(op_base) + $urandom_range(0, NUM_OPS - 1);
        itm.op     = (op32 > 32'hFFFF) ? op_base : t_code'(op32);
        case ($urandom_range(0, 3))
            0: itm.oc = ok_code;
            1: itm.oc = tmo_code;
            2: itm.oc = outcome_limit;
            default: itm.oc = t_code'($urandom_range(0, outcome_limit));
        endcase
        case ($urandom_range(0, 5))
            0: itm.dur = '0;
            1: itm.dur = '1;
            2: itm.dur = $urandom_range(0, 15);
            3: itm.dur = $urandom;
            default: itm.dur = $urandom_range(0, 1000);
        endcase
        if (pick < 3) begin
            itm.act    = ACT_UNUSED;
            itm.len_ok = 1'($urandom_range(0, 1));
            itm.ver    = t_code'($urandom);
        end else if (pick < 8) begin
            itm.act = ACT_CLEAR;
        end else if (pick < 20) begin
            itm.act = ACT_QUERY;
        end else if (pick < 32) begin
            // broken observation: one field disturbed each, though a random value may still be valid
            case ($urandom_range(0, 6))
                0: itm.len_ok = 1'b0;
                1: itm.ver = t_code'($urandom);
                2: itm.op = t_code'($urandom);
                3: itm.oc = t_code'($urandom);
                4: itm.op = op_base - t_code'(1);
                5: itm.op = op_base + t_code'(NUM_OPS);
                default: itm.oc = outcome_limit + t_code'(1);
            endcase
        end
        return itm;
    endfunction

    // transfer tracking, prediction, result checks and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            out_xfer = res_if.valid && res_if.ready;
            in_xfer  = item_if.valid && item_if.ready;
            if (out_xfer)
                check_snapshot({res_if.generation, res_if.request_count,
                                res_if.success_count, res_if.error_count,
                                res_if.timeout_count, res_if.min_latency,
                                res_if.max_latency, res_if.avg_latency,
                                res_if.observations_received, res_if.malformed_rejected});
            if (in_xfer) begin
                taken_item.act    = item_if.action;
                taken_item.len_ok = item_if.length_ok;
                taken_item.ver    = item_if.version;
                taken_item.op     = item_if.operation;
                taken_item.oc     = item_if.outcome;
                taken_item.dur    = item_if.duration;
                stats_step(taken_item);
            end
            if (in_xfer || out_xfer)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // item driver with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_xfer)
                drv_holding = 1'b0;
            if (!drv_holding) begin
                if (send_gap != 0) begin
                    send_gap--;
                    item_if.valid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    item_if.valid <= 1'b0;
                end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(0, 5);
                    item_if.valid <= 1'b0;
                end else begin
                    next_item = pending_items.pop_front();
                    item_if.action    <= next_item.act;
                    item_if.length_ok <= next_item.len_ok;
                    item_if.version   <= next_item.ver;
                    item_if.operation <= next_item.op;
                    item_if.outcome   <= next_item.oc;
                    item_if.duration  <= next_item.dur;
                    item_if.valid     <= 1'b1;
                    drv_holding = 1'b1;
                end
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            res_if.ready <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            recv_gap = $urandom_range(0, 5);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    task automatic write_reg(t_cfg_idx idx, t_code val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_EXP_VERSION:  want_version  = val;
            CFG_FIRST_OP:     op_base       = val;
            CFG_SUCCESS:      ok_code       = val;
            CFG_TIMEOUT:      tmo_code      = val;
            CFG_LAST_OUTCOME: outcome_limit = val;
            default: ;
        endcase
    endtask

    task automatic program_settings(t_code ver, t_code base, t_code ok, t_code tmo, t_code lim);
        write_reg(CFG_EXP_VERSION, ver);
        write_reg(CFG_FIRST_OP, base);
        write_reg(CFG_SUCCESS, ok);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_LAST_OUTCOME, lim);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait until every item is taken and every result is back
    task automatic settle();
        while (pending_items.size() != 0 || drv_holding || snapshot_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        t_code lim;
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        item_if.valid     = 1'b0;
        item_if.action    = '0;
        item_if.length_ok = 1'b0;
        item_if.version   = '0;
        item_if.operation = '0;
        item_if.outcome   = '0;
        item_if.duration  = '0;
        res_if.ready      = 1'b0;
        want_version      = RST_EXP_VERSION;
        op_base           = RST_FIRST_OP;
        ok_code           = RST_SUCCESS;
        tmo_code          = RST_TIMEOUT;
        outcome_limit     = RST_LAST_OUTCOME;
        gen_now           = RST_GENERATION;
        clear_tallies();

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty query, unset minimum, every reject reason, ignored action
        pending_items.push_back(make_item(ACT_QUERY, 1'b1, '0, '0, '0, '0));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd1, 16'd1, 16'd0, '0));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd1, 16'd2, 16'd1, '1));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd1, 16'd3, 16'd2, 32'd100));
        pending_items.push_back(make_item(ACT_QUERY, 1'b0, '1, '1, '1, '1));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b0, 16'd1, 16'd1, 16'd0, 32'd7));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd0, 16'd1, 16'd0, 32'd7));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'hFFFF, 16'd1, 16'd0, 32'd7));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd1, 16'd0, 16'd0, 32'd7));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd1, 16'd4, 16'd0, 32'd7));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd1, 16'hFFFF, 16'd0, 32'd7));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd1, 16'd1, 16'd3, 32'd7));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd1, 16'd2, 16'hFFFF, 32'd7));
        pending_items.push_back(make_item(ACT_UNUSED, 1'b1, 16'd1, 16'd1, 16'd0, '1));
        pending_items.push_back(make_item(ACT_QUERY, 1'b1, '0, '0, '0, '0));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd1, 16'd2, 16'd0, 32'd5));
        pending_items.push_back(make_item(ACT_QUERY, 1'b1, '0, '0, '0, '0));
        pending_items.push_back(make_item(ACT_CLEAR, 1'b1, '0, '0, '0, '0));
        pending_items.push_back(make_item(ACT_QUERY, 1'b1, '0, '0, '0, '0));
        pending_items.push_back(make_item(ACT_OBSERVE, 1'b1, 16'd1, 16'd1, 16'd1, 32'hAAAA5555));
        pending_items.push_back(make_item(ACT_QUERY, 1'b1, '0, '0, '0, '0));
        settle();

        // random phases, each under its own settings
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: program_settings(RST_EXP_VERSION, RST_FIRST_OP, RST_SUCCESS,
                                    RST_TIMEOUT, RST_LAST_OUTCOME);
                // all low: success and timeout share a code
                1: program_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                2: program_settings(16'hFFFF, 16'd65533, 16'hFFFF, 16'hFFFE, 16'hFFFF);
                // operation range runs past the top code
                3: program_settings(16'd7, 16'hFFFF, 16'd3, 16'd5, 16'd9);
                default: begin
                    lim = t_code'($urandom_range(0, 24));
                    program_settings(t_code'($urandom), t_code'($urandom_range(0, 65533)),
                                     t_code'($urandom_range(0, lim)),
                                     t_code'($urandom_range(0, lim)), lim);
                end
            endcase
            quiet_mode = (p == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_items.push_back(random_item());
            if (p == 4)
                long_hold_req = 1'b1;
            settle();
        end

        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && snapshot_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lsm_pkg.sv
sv/lsm_in_if.sv
sv/lsm_out_if.sv
sv/lsm_store.sv
sv/lsm_div.sv
sv/latency_stats_monitor.sv
test/tb.sv
